// ===== design/assert_macros.svh =====
// assertion macros for the rtl files, included by bsss_datapath
// expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BSSS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define BSSS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BSSS_ASSERT_IMP(label, ante, cons, msg)
`define BSSS_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== design/bsss_pkg.sv =====
// shared constants, microcode types and status struct for the swap sequence unit
// no dependencies
`timescale 1ns / 1ps
package bsss_pkg;
   localparam int MAX_LEN    = 8;
   localparam int NAME_WIDTH = 8;
   localparam int ORDER_W    = 3;
   localparam int BOND_W     = 8;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int CNT_W      = $clog2(MAX_LEN + 1);
   localparam int CMP_W      = (ORDER_W > CNT_W) ? ORDER_W : CNT_W;
   localparam int STEP_W     = 3;

   typedef enum logic [STEP_W-1:0] {
      STEP_IDLE,
      STEP_INIT,
      STEP_LOAD_CUR,
      STEP_COMPARE,
      STEP_ADVANCE,
      STEP_PASS_END,
      STEP_FINISH
   } step_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_START,
      COND_SHORT,
      COND_PASS_MORE,
      COND_MORE_PASSES
   } cond_type;

   typedef struct packed {
      logic     wait_item;
      logic     init;
      logic     load_cur;
      logic     compare;
      logic     advance;
      logic     pass_end;
      logic     finish;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic start;
      logic short_seq;
      logic pass_more;
      logic more_passes;
      logic stall;
   } status_type;
endpackage

// ===== design/bsss_req_if.sv =====
// request channel interface: order value, bond name and last flag
// depends on bsss_pkg
`timescale 1ns / 1ps
interface bsss_req_if;
   import bsss_pkg::*;

   logic               valid;
   logic               ready;
   logic [ORDER_W-1:0] order_value;
   logic [BOND_W-1:0]  bond_name;
   logic               is_last;

   modport source (output valid, output order_value, output bond_name, output is_last,
                   input ready);
   modport sink (input valid, input order_value, input bond_name, input is_last,
                 output ready);
endinterface

// ===== design/bsss_rsp_if.sv =====
// response channel interface: swapped bond names and run flags
// depends on bsss_pkg
`timescale 1ns / 1ps
interface bsss_rsp_if;
   import bsss_pkg::*;

   logic              valid;
   logic              ready;
   logic [BOND_W-1:0] first_bond;
   logic [BOND_W-1:0] second_bond;
   logic              swap_valid;
   logic              last_swap;

   modport source (output valid, output first_bond, output second_bond,
                   output swap_valid, output last_swap, input ready);
   modport sink (input valid, input first_bond, input second_bond,
                 input swap_valid, input last_swap, output ready);
endinterface

// ===== design/bsss_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module bsss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/bsss_sequencer.sv =====
// microcode rom and step counter; issues one control word per cycle
// depends on bsss_pkg
`timescale 1ns / 1ps
module bsss_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  bsss_pkg::status_type   status,
   output bsss_pkg::ctrl_word_type ctrl
);
   import bsss_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     cond_true;

   function automatic ctrl_word_type rom_word(input step_type s);
      ctrl_word_type w;
      w = '0;
      w.cond   = COND_NONE;
      w.target = STEP_IDLE;
      unique case (s)
         STEP_IDLE: begin
            w.wait_item = 1'b1;
            w.cond      = COND_NO_START;
            w.target    = STEP_IDLE;
         end
         STEP_INIT: begin
            w.init   = 1'b1;
            w.cond   = COND_SHORT;
            w.target = STEP_FINISH;
         end
         STEP_LOAD_CUR: begin
            w.load_cur = 1'b1;
         end
         STEP_COMPARE: begin
            w.compare = 1'b1;
         end
         STEP_ADVANCE: begin
            w.advance = 1'b1;
            w.cond    = COND_PASS_MORE;
            w.target  = STEP_COMPARE;
         end
         STEP_PASS_END: begin
            w.pass_end = 1'b1;
            w.cond     = COND_MORE_PASSES;
            w.target   = STEP_LOAD_CUR;
         end
         STEP_FINISH: begin
            w.finish = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   assign ctrl = rom_word(step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      unique case (ctrl.cond)
         COND_NONE:        cond_true = 1'b0;
         COND_ALWAYS:      cond_true = 1'b1;
         COND_NO_START:    cond_true = !status.start;
         COND_SHORT:       cond_true = status.short_seq;
         COND_PASS_MORE:   cond_true = status.pass_more;
         COND_MORE_PASSES: cond_true = status.more_passes;
         default:          cond_true = 1'b0;
      endcase

      if (status.stall) begin
         step_in = step_ff;
      end else if (cond_true) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_type'(step_ff + STEP_W'(1));
      end
   end
endmodule

// ===== design/bsss_datapath.sv =====
// load path, order and name stores, carried-max compare and response register
// depends on bsss_pkg, bsss_req_if, bsss_rsp_if, bsss_ram, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bsss_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  bsss_pkg::ctrl_word_type ctrl,
   output bsss_pkg::status_type    status,
   bsss_req_if.sink                req_ch,
   bsss_rsp_if.source              rsp_ch
);
   import bsss_pkg::*;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   lim_ff, lim_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [ORDER_W-1:0] cur_ff, cur_in;
   logic               swap_ff, swap_in;
   logic               lo_ok_ff, lo_ok_in;
   logic               hi_ok_ff, hi_ok_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [BOND_W-1:0]  pend_first_ff, pend_first_in;
   logic [BOND_W-1:0]  pend_second_ff, pend_second_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BOND_W-1:0]  first_ff, first_in;
   logic [BOND_W-1:0]  second_ff, second_in;
   logic               swap_valid_ff, swap_valid_in;
   logic               last_ff, last_in;

   logic                  accept;
   logic                  out_free;
   logic                  stall;
   logic                  push;
   logic                  gt;
   logic [ORDER_W-1:0]    nxt;
   logic [BOND_W-1:0]     name_lo, name_hi;

   logic                  order_wr_en;
   logic [ADDR_W-1:0]     order_wr_addr;
   logic [ORDER_W-1:0]    order_wr_data;
   logic                  order_rd_en;
   logic [ADDR_W-1:0]     order_rd_addr;
   logic                  name_wr_en;
   logic                  name_rd_en;
   logic [NAME_WIDTH-1:0] name_a_data, name_b_data;

   // order store, sorted in place during a run
   bsss_ram #(.WIDTH(ORDER_W), .DEPTH(MAX_LEN)) u_order_ram (
      .clock   (clock),
      .wr_en   (order_wr_en),
      .wr_addr (order_wr_addr),
      .wr_data (order_wr_data),
      .rd_en   (order_rd_en),
      .rd_addr (order_rd_addr),
      .rd_data (nxt)
   );

   // two copies of the name store, one per looked-up value
   bsss_ram #(.WIDTH(NAME_WIDTH), .DEPTH(MAX_LEN)) u_name_a_ram (
      .clock   (clock),
      .wr_en   (name_wr_en),
      .wr_addr (ADDR_W'(count_ff)),
      .wr_data (NAME_WIDTH'(req_ch.bond_name)),
      .rd_en   (name_rd_en),
      .rd_addr (ADDR_W'(nxt)),
      .rd_data (name_a_data)
   );

   bsss_ram #(.WIDTH(NAME_WIDTH), .DEPTH(MAX_LEN)) u_name_b_ram (
      .clock   (clock),
      .wr_en   (name_wr_en),
      .wr_addr (ADDR_W'(count_ff)),
      .wr_data (NAME_WIDTH'(req_ch.bond_name)),
      .rd_en   (name_rd_en),
      .rd_addr (ADDR_W'(cur_ff)),
      .rd_data (name_b_data)
   );

   assign req_ch.ready = ctrl.wait_item;
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign stall        = (ctrl.advance && swap_ff && pend_valid_ff && !out_free) ||
                         (ctrl.finish && !out_free);
   assign gt           = cur_ff > nxt;
   assign name_lo      = lo_ok_ff ? BOND_W'(name_a_data) : '0;
   assign name_hi      = hi_ok_ff ? BOND_W'(name_b_data) : '0;

   assign status.start       = accept && req_ch.is_last;
   assign status.short_seq   = count_ff < CNT_W'(2);
   assign status.pass_more   = (j_ff + CNT_W'(1)) != lim_ff;
   assign status.more_passes = lim_ff != CNT_W'(1);
   assign status.stall       = stall;

   always_comb begin
      count_in       = count_ff;
      lim_in         = lim_ff;
      j_in           = j_ff;
      cur_in         = cur_ff;
      swap_in        = swap_ff;
      lo_ok_in       = lo_ok_ff;
      hi_ok_in       = hi_ok_ff;
      pend_valid_in  = pend_valid_ff;
      pend_first_in  = pend_first_ff;
      pend_second_in = pend_second_ff;
      order_wr_en    = 1'b0;
      order_wr_addr  = ADDR_W'(count_ff);
      order_wr_data  = req_ch.order_value;
      order_rd_en    = 1'b0;
      order_rd_addr  = '0;
      name_wr_en     = 1'b0;
      name_rd_en     = 1'b0;
      push           = 1'b0;
      first_in       = '0;
      second_in      = '0;
      swap_valid_in  = 1'b0;
      last_in        = 1'b0;

      // load: items past the store depth are dropped
      if (accept && (count_ff < CNT_W'(MAX_LEN))) begin
         order_wr_en = 1'b1;
         name_wr_en  = 1'b1;
         count_in    = count_ff + CNT_W'(1);
      end

      if (ctrl.init) begin
         lim_in        = count_ff - CNT_W'(1);
         j_in          = '0;
         pend_valid_in = 1'b0;
         order_rd_en   = 1'b1;
      end

      if (ctrl.load_cur) begin
         cur_in        = nxt;
         order_rd_en   = 1'b1;
         order_rd_addr = ADDR_W'(j_ff + CNT_W'(1));
      end

      // the larger value is carried forward, the smaller one settles at j
      if (ctrl.compare) begin
         order_wr_en   = 1'b1;
         order_wr_addr = ADDR_W'(j_ff);
         order_wr_data = gt ? nxt : cur_ff;
         name_rd_en    = 1'b1;
         swap_in       = gt;
         lo_ok_in      = CMP_W'(nxt) < CMP_W'(count_ff);
         hi_ok_in      = CMP_W'(cur_ff) < CMP_W'(count_ff);
         if (!gt) begin
            cur_in = nxt;
         end
      end

      // a swap is held back until the next swap or the finish, so the final one can carry the last flag
      if (ctrl.advance && !stall) begin
         if (swap_ff) begin
            if (pend_valid_ff) begin
               push          = 1'b1;
               first_in      = pend_first_ff;
               second_in     = pend_second_ff;
               swap_valid_in = 1'b1;
            end
            pend_valid_in  = 1'b1;
            pend_first_in  = name_lo;
            pend_second_in = name_hi;
         end
         j_in = j_ff + CNT_W'(1);
         if (status.pass_more) begin
            order_rd_en   = 1'b1;
            order_rd_addr = ADDR_W'(j_ff + CNT_W'(2));
         end
      end

      if (ctrl.pass_end) begin
         lim_in      = lim_ff - CNT_W'(1);
         j_in        = '0;
         order_rd_en = 1'b1;
      end

      if (ctrl.finish && !stall) begin
         push    = 1'b1;
         last_in = 1'b1;
         if (pend_valid_ff) begin
            first_in      = pend_first_ff;
            second_in     = pend_second_ff;
            swap_valid_in = 1'b1;
         end
         pend_valid_in = 1'b0;
         count_in      = '0;
      end

      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff         <= lim_in;
      j_ff           <= j_in;
      cur_ff         <= cur_in;
      swap_ff        <= swap_in;
      lo_ok_ff       <= lo_ok_in;
      hi_ok_ff       <= hi_ok_in;
      pend_first_ff  <= pend_first_in;
      pend_second_ff <= pend_second_in;
      if (push) begin
         first_ff      <= first_in;
         second_ff     <= second_in;
         swap_valid_ff <= swap_valid_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.first_bond  = first_ff;
   assign rsp_ch.second_bond = second_ff;
   assign rsp_ch.swap_valid  = swap_valid_ff;
   assign rsp_ch.last_swap   = last_ff;

   `BSSS_ASSERT_IMP(a_idle_no_pending, ctrl.wait_item, !pend_valid_ff, "swap pending while idle")
   `BSSS_ASSERT_IMP(a_compare_in_pass, ctrl.compare, j_ff < lim_ff, "compare beyond pass limit")
   `BSSS_ASSERT_NXT(a_finish_last, ctrl.finish && !stall, rsp_valid_ff && last_ff, "run end lost")
   `BSSS_ASSERT_IMP(a_noswap_is_last, rsp_valid_ff, swap_valid_ff || last_ff, "stray empty word")
   `BSSS_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_LEN), "count past depth")
endmodule

// ===== design/bubble_sort_swap_sequence_unit.sv =====
// load: words are taken only while idle; the last word starts a sort of the n held values,
// which response back-pressure can stall; each compare is a compare step (name store read)
// then an advance step (next order store read)
// throughput: one sequence at a time; no word is taken while a sort runs
// reset: synchronous active high, clears the step counter, fill count, pending swap flag and response valid
`timescale 1ns / 1ps
module bubble_sort_swap_sequence_unit (
   input logic        clock,
   input logic        reset,
   bsss_req_if.sink   req_ch,
   bsss_rsp_if.source rsp_ch
);
   import bsss_pkg::*;

   // control word from the rom, status back for jumps and stalls
   ctrl_word_type ctrl;
   status_type    status;

   // step counter plus microcode rom: load, init, then per pass
   // load current, compare/advance per pair, pass end, finish
   bsss_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // stores, carried-max compare, pending swap and response register
   bsss_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );
endmodule

// ===== dv/bubble_sort_swap_sequence_unit_tb.sv =====
// testbench for bubble_sort_swap_sequence_unit: loads order sequences, checks every swap word
// depends on bsss_pkg, bsss_req_if, bsss_rsp_if and the unit itself
`timescale 1ns / 1ps
module bubble_sort_swap_sequence_unit_tb;
   import bsss_pkg::*;

   // how the order values of one sequence are chosen
   typedef enum int {
      FILL_RANDOM,
      FILL_PERMUTED,
      FILL_NARROW,
      FILL_REVERSED
   } fill_style_type;

   // one word on the response channel
   typedef struct packed {
      logic [BOND_W-1:0] first_bond;
      logic [BOND_W-1:0] second_bond;
      logic              swap_valid;
      logic              last_swap;
   } swap_word_type;

   localparam int RANDOM_WORDS = 420;
   // quiet time after a drain, long enough to cover the tail of a full sort of eight values
   localparam int SETTLE_CYCLES = 100;
   // receiver hold-off, long enough for the unit to fill and stall its input
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset;

   bsss_req_if req_ch ();
   bsss_rsp_if rsp_ch ();

   bubble_sort_swap_sequence_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // 12 ns period
   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor state: the sequence held so far and the swap words owed
   // ------------------------------------------------------------------
   logic [ORDER_W-1:0] held_order [MAX_LEN];
   logic [BOND_W-1:0]  held_name  [MAX_LEN];
   int unsigned        held_count;
   swap_word_type      pending_swaps [$];

   int unsigned words_accepted;
   int unsigned fail_count;

   // knobs shared by the test tasks and the two channel sides
   bit tx_idle_en;
   bit rx_idle_en;
   int unsigned hold_left;

   // name looked up by an order value; values past the held count give zero
   function automatic logic [BOND_W-1:0] name_for_value(input logic [ORDER_W-1:0] value);
      if (value < held_count && value < MAX_LEN) return held_name[value];
      return '0;
   endfunction

   // append one word to the tail of the owed list
   function automatic void owe_word(input swap_word_type word);
      pending_swaps.insert(pending_swaps.size(), word);
   endfunction

   // store one accepted word; a last word bubble-sorts the held values and
   // queues one swap word per exchange, in exchange order
   function automatic void load_and_sort(input logic [ORDER_W-1:0] order_value,
                                         input logic [BOND_W-1:0] bond_name,
                                         input logic is_last);
      logic [ORDER_W-1:0] work [MAX_LEN];
      logic [ORDER_W-1:0] tmp;
      swap_word_type      word;
      int unsigned        i, j, swaps;
      // words past the capacity are dropped, but a dropped last word still sorts
      if (held_count < MAX_LEN) begin
         held_order[held_count] = order_value;
         held_name[held_count]  = bond_name;
         held_count++;
      end
      if (!is_last) return;
      for (i = 0; i < held_count; i++) work[i] = held_order[i];
      swaps = 0;
      for (i = 0; i + 1 < held_count; i++) begin
         for (j = 0; j + 1 < held_count - i; j++) begin
            // strict compare: equal values never swap
            if (work[j] > work[j+1]) begin
               word.first_bond  = name_for_value(work[j+1]);
               word.second_bond = name_for_value(work[j]);
               word.swap_valid  = 1'b1;
               word.last_swap   = 1'b0;
               owe_word(word);
               tmp       = work[j];
               work[j]   = work[j+1];
               work[j+1] = tmp;
               swaps++;
            end
         end
      end
      if (swaps == 0) begin
         // nothing moved: one empty word closes the run
         word = '{first_bond: '0, second_bond: '0, swap_valid: 1'b0, last_swap: 1'b1};
         owe_word(word);
      end else begin
         word = pending_swaps.pop_back();
         word.last_swap = 1'b1;
         owe_word(word);
      end
      held_count = 0;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   // ------------------------------------------------------------------
   // receiver side: checks each accepted word, then picks next ready
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      swap_word_type got, want;
      logic          next_ready;
      int unsigned   rx_gap;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.first_bond  = rsp_ch.first_bond;
            got.second_bond = rsp_ch.second_bond;
            got.swap_valid  = rsp_ch.swap_valid;
            got.last_swap   = rsp_ch.last_swap;
            if (pending_swaps.size() == 0) begin
               note_failure($sformatf("unexpected word first=%0d second=%0d valid=%b last=%b",
                  got.first_bond, got.second_bond, got.swap_valid, got.last_swap));
            end else begin
               want = pending_swaps.pop_front();
               if (got.first_bond !== want.first_bond || got.second_bond !== want.second_bond ||
                   got.swap_valid !== want.swap_valid || got.last_swap !== want.last_swap) begin
                  note_failure($sformatf(
                     "expected first=%0d second=%0d valid=%b last=%b, got %0d %0d %b %b",
                     want.first_bond, want.second_bond, want.swap_valid, want.last_swap,
                     got.first_bond, got.second_bond, got.swap_valid, got.last_swap));
               end
            end
            rx_gap = rx_idle_en ? $urandom_range(0, 3) : 0;
         end
         // a long hold-off asked by a test wins over the per-word gap
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // ------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------

   // offer one word, after an optional gap, and wait until it is taken
   task automatic send_word(input logic [ORDER_W-1:0] order_value,
                            input logic [BOND_W-1:0] bond_name,
                            input logic is_last);
      int unsigned gap;
      gap = tx_idle_en ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.order_value <= order_value;
      req_ch.bond_name   <= bond_name;
      req_ch.is_last     <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_accepted++;
      load_and_sort(order_value, bond_name, is_last);
   endtask

   // one sequence of len words, the last one flagged
   task automatic send_sequence(input int unsigned len, input fill_style_type style,
                                input bit positional);
      logic [ORDER_W-1:0] vals [12];
      logic [ORDER_W-1:0] tmp;
      logic [BOND_W-1:0]  name;
      int unsigned        i, k, span;
      span = (len > MAX_LEN) ? MAX_LEN : len;
      for (i = 0; i < len; i++) begin
         case (style)
            FILL_PERMUTED: vals[i] = ORDER_W'(i % span);
            FILL_NARROW:   vals[i] = ORDER_W'($urandom_range(0, 2));
            FILL_REVERSED: vals[i] = ORDER_W'((i < span) ? span - 1 - i : $urandom_range(0, 7));
            default:       vals[i] = ORDER_W'($urandom_range(0, 7));
         endcase
      end
      // shuffle the first span entries for a true permutation
      if (style == FILL_PERMUTED) begin
         for (i = span; i > 1; i--) begin
            k = $urandom_range(0, i - 1);
            tmp        = vals[i-1];
            vals[i-1]  = vals[k];
            vals[k]    = tmp;
         end
      end
      for (i = 0; i < len; i++) begin
         name = positional ? BOND_W'(i) : BOND_W'($urandom_range(0, 255));
         send_word(vals[i], name, i == len - 1);
      end
   endtask

   // sender stops until every owed word is back, then lets the unit settle
   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_swaps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // corner cases: single word, full reversal with overflow, ties,
   // already sorted and order values past the held count
   task automatic test_directed_cases();
      int unsigned i;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      // one-word sequence gives the no-swap word
      send_word(3'd7, 8'd255, 1'b1);
      // reversed eight values with positional names: the most swaps a run has;
      // two extra words are dropped and the dropped last one starts the sort
      for (i = 0; i < MAX_LEN; i++) send_word(ORDER_W'(MAX_LEN - 1 - i), BOND_W'(i), 1'b0);
      send_word(3'd0, 8'd0, 1'b0);
      send_word(3'd7, 8'd255, 1'b1);
      // ties must never swap
      send_word(3'd2, 8'd17, 1'b0);
      send_word(3'd2, 8'd34, 1'b0);
      send_word(3'd1, 8'd51, 1'b0);
      send_word(3'd1, 8'd68, 1'b1);
      // already ascending: no exchange
      send_word(3'd0, 8'd255, 1'b0);
      send_word(3'd1, 8'd0, 1'b0);
      send_word(3'd2, 8'd128, 1'b1);
      // value 3 is past a count of two and looks up name zero
      send_word(3'd3, 8'd200, 1'b0);
      send_word(3'd0, 8'd100, 1'b1);
      pause_until_drained();
   endtask

   // receiver holds off while the sender keeps offering full sequences,
   // so the sort stalls on its output and the input stops taking words
   task automatic test_back_pressure();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      hold_left  = HOLD_OFF_CYCLES;
      send_sequence(MAX_LEN, FILL_REVERSED, 1'b0);
      send_sequence(MAX_LEN, FILL_PERMUTED, 1'b1);
      send_sequence(MAX_LEN, FILL_RANDOM, 1'b0);
      pause_until_drained();
   endtask

   // random sequences: mostly two to eight words, some single, some overflowing
   task automatic test_random_sequences();
      int unsigned start, len, pick;
      fill_style_type style;
      start = words_accepted;
      while (words_accepted - start < RANDOM_WORDS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)     len = $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
         else if (pick < 3) len = 1;
         else               len = $urandom_range(2, MAX_LEN);
         style = fill_style_type'($urandom_range(0, 3));
         // stretches with and without idling on either side
         tx_idle_en = ($urandom_range(0, 3) != 0);
         rx_idle_en = ($urandom_range(0, 3) != 0);
         send_sequence(len, style, $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) pause_until_drained();
      end
      req_ch.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      held_count     = 0;
      words_accepted = 0;
      fail_count     = 0;
      hold_left      = 0;
      tx_idle_en     = 1'b0;
      rx_idle_en     = 1'b0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.order_value <= '0;
      req_ch.bond_name   <= '0;
      req_ch.is_last     <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_back_pressure();
      test_random_sequences();

      // wait out everything owed, then a quiet tail for stray words
      while (pending_swaps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_swaps.size() != 0)
         note_failure($sformatf("%0d words never arrived", pending_swaps.size()));
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #(5_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/bsss_pkg.sv
design/bsss_req_if.sv
design/bsss_rsp_if.sv
design/bsss_ram.sv
design/bsss_sequencer.sv
design/bsss_datapath.sv
design/bubble_sort_swap_sequence_unit.sv
dv/bubble_sort_swap_sequence_unit_tb.sv
